[rtl/particle_predictor_corrector_top_assert.svh]
// assertion macros shared by the particle predictor corrector modules
`ifndef PARTICLE_PREDICTOR_CORRECTOR_TOP_ASSERT_SVH
`define PARTICLE_PREDICTOR_CORRECTOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PPC_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PPC_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) pre |=> post) else $error(msg);
`else
`define PPC_ASSERT(name, clk, rst, prop, msg)
`define PPC_ASSERT_NEXT(name, clk, rst, pre, post, msg)
`endif
`endif

[rtl/ppc_pkg.sv]
// types and constants of the particle predictor corrector
package ppc_pkg;

   localparam int DATA_W        = 32;
   localparam int ERR_W         = 31;
   localparam int MAG_W         = DATA_W + 1;
   localparam int PROD_W        = MAG_W + DATA_W;
   localparam int SUM_W         = PROD_W + 1;
   localparam int SHIFT_MUL     = 24;
   localparam int SHIFT_HALF    = 25;
   localparam int SHIFT_QUARTER = 26;
   localparam int Q_W           = SUM_W - SHIFT_MUL;

   localparam logic [DATA_W-1:0] TIME_STEP_RESET = 32'd1677722;

   localparam logic [1:0] ACT_PREDICT = 2'd0;
   localparam logic [1:0] ACT_CORRECT = 2'd1;
   localparam logic [1:0] ACT_ERROR   = 2'd2;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_A,
      OP_B,
      OP_C,
      OP_H,
      OP_G,
      OP_V,
      OP_D
   } op_tag_type;

   typedef struct packed {
      logic       load;
      op_tag_type op_tag;
      logic       commit;
   } dp_cmd_type;

   typedef struct packed {
      logic is_predict;
      logic is_correct;
      logic out_free;
   } dp_status_type;

endpackage

[rtl/ppc_controller.sv]
// sequencer that schedules the shared multiplier and the result commit
`include "particle_predictor_corrector_top_assert.svh"

module ppc_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output ppc_pkg::dp_cmd_type   cmd,
   input  ppc_pkg::dp_status_type status
);
   import ppc_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE   = 12'b000000000001,
      S_LD_A   = 12'b000000000010,
      S_LD_H   = 12'b000000000100,
      S_WAIT_1 = 12'b000000001000,
      S_LD_B   = 12'b000000010000,
      S_LD_V   = 12'b000000100000,
      S_WAIT_2 = 12'b000001000000,
      S_LD_C   = 12'b000010000000,
      S_LD_D   = 12'b000100000000,
      S_WAIT_3 = 12'b001000000000,
      S_WAIT_4 = 12'b010000000000,
      S_FINAL  = 12'b100000000000
   } ctrl_state_type;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   assign req_stall = reset || (state_ff != S_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.op_tag = OP_NONE;
      cmd.commit = 1'b0;
      case (state_ff)
         S_IDLE: begin
            cmd.load = req_valid && !req_stall;
            if (cmd.load) begin
               state_in = S_LD_A;
            end
         end
         S_LD_A: begin
            cmd.op_tag = OP_A;
            state_in   = S_LD_H;
         end
         S_LD_H: begin
            if (status.is_predict) begin
               cmd.op_tag = OP_H;
            end else if (status.is_correct) begin
               cmd.op_tag = OP_G;
            end
            state_in = S_WAIT_1;
         end
         S_WAIT_1: begin
            state_in = S_LD_B;
         end
         S_LD_B: begin
            cmd.op_tag = OP_B;
            state_in   = S_LD_V;
         end
         S_LD_V: begin
            if (status.is_predict) begin
               cmd.op_tag = OP_V;
            end
            state_in = S_WAIT_2;
         end
         S_WAIT_2: begin
            state_in = S_LD_C;
         end
         S_LD_C: begin
            cmd.op_tag = OP_C;
            state_in   = S_LD_D;
         end
         S_LD_D: begin
            if (status.is_predict) begin
               cmd.op_tag = OP_D;
            end
            state_in = S_WAIT_3;
         end
         S_WAIT_3: begin
            state_in = S_WAIT_4;
         end
         S_WAIT_4: begin
            state_in = S_FINAL;
         end
         S_FINAL: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `PPC_ASSERT_NEXT(a_accept_starts, clock, reset, cmd.load, state_ff == S_LD_A, "accepted transaction did not start the schedule")
   `PPC_ASSERT(a_commit_only_final, clock, reset, cmd.commit |-> (state_ff == S_FINAL && !req_stall == 1'b0), "commit outside the final step")

endmodule

[rtl/ppc_datapath.sv]
// operand select, shared multiplier, rounding, final sums and result register
`include "particle_predictor_corrector_top_assert.svh"

module ppc_datapath #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ppc_pkg::dp_cmd_type                 cmd,
   output ppc_pkg::dp_status_type              status,
   input  logic                                csr_write,
   input  logic        [ppc_pkg::DATA_W-1:0]   csr_time_step,
   input  logic        [1:0]                   req_action,
   input  logic                                req_clear_max,
   input  logic signed [ppc_pkg::DATA_W-1:0]   req_position,
   input  logic signed [ppc_pkg::DATA_W-1:0]   req_momentum,
   input  logic signed [ppc_pkg::DATA_W-1:0]   req_force_now,
   input  logic signed [ppc_pkg::DATA_W-1:0]   req_force_pred,
   input  logic        [ppc_pkg::DATA_W-1:0]   req_inv_mass,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic signed [ppc_pkg::DATA_W-1:0]   rsp_new_position,
   output logic signed [ppc_pkg::DATA_W-1:0]   rsp_new_momentum,
   output logic        [ppc_pkg::ERR_W-1:0]    rsp_position_error,
   output logic        [ppc_pkg::ERR_W-1:0]    rsp_max_error,
   output logic                                rsp_saturated
);
   import ppc_pkg::*;

   localparam int EFF_WIDTH = (VALUE_WIDTH > DATA_W) ? DATA_W :
                              ((VALUE_WIDTH < 16) ? 16 : VALUE_WIDTH);
   localparam longint unsigned VAL_MAX_L = (64'd1 << (EFF_WIDTH - 1)) - 64'd1;
   localparam logic [Q_W-1:0] MAX_Q  = Q_W'(VAL_MAX_L);
   localparam logic [Q_W-1:0] MAX_Q1 = Q_W'(VAL_MAX_L + 64'd1);
   localparam logic signed [DATA_W-1:0] VMAX_D = DATA_W'(VAL_MAX_L);
   localparam logic signed [DATA_W-1:0] VMIN_D = -VMAX_D - 1;
   localparam logic signed [MAG_W-1:0]  VMAX_S = MAG_W'(VAL_MAX_L);
   localparam logic signed [MAG_W-1:0]  VMIN_S = -VMAX_S - 1;

   function automatic logic signed [DATA_W-1:0] clip(input logic signed [MAG_W-1:0] x);
      return (x > VMAX_S) ? VMAX_D : ((x < VMIN_S) ? VMIN_D : DATA_W'(x));
   endfunction

   function automatic logic clipped(input logic signed [MAG_W-1:0] x);
      return (x > VMAX_S) || (x < VMIN_S);
   endfunction

   // configuration and captured transaction
   logic        [DATA_W-1:0] time_step_ff;
   logic        [1:0]        action_ff;
   logic                     clear_ff;
   logic signed [DATA_W-1:0] pos_ff;
   logic signed [DATA_W-1:0] mom_ff;
   logic signed [DATA_W-1:0] fnow_ff;
   logic signed [DATA_W-1:0] fpred_ff;
   logic        [DATA_W-1:0] imass_ff;

   // operand stage
   logic signed [MAG_W-1:0]  opx;
   logic        [DATA_W-1:0] op_y_in;
   logic        [MAG_W-1:0]  op_mag_in;
   logic        [MAG_W-1:0]  op_mag_ff;
   logic        [DATA_W-1:0] op_y_ff;
   logic                     op_neg_ff;
   op_tag_type               op_tag_ff;

   // product stage
   logic        [PROD_W-1:0] prod_ff;
   logic                     mul_neg_ff;
   op_tag_type               mul_tag_ff;

   // rounding stage
   logic        [SUM_W-1:0]  rnd_sum;
   logic        [Q_W-1:0]    rnd_q;
   logic                     rnd_sat;
   logic signed [DATA_W-1:0] rnd_val;

   logic signed [DATA_W-1:0] a_ff;
   logic signed [DATA_W-1:0] hg_ff;
   logic signed [DATA_W-1:0] b_ff;
   logic signed [DATA_W-1:0] v_ff;
   logic signed [DATA_W-1:0] c_ff;
   logic signed [DATA_W-1:0] d_ff;
   logic                     sat_ff;

   // error magnitude
   logic        [ERR_W-1:0]  err_in;
   logic                     err_cap_in;
   logic        [ERR_W-1:0]  err_ff;
   logic                     err_cap_ff;

   // final sums
   logic signed [MAG_W-1:0]  sum_pd;
   logic signed [MAG_W-1:0]  sum_pc;
   logic signed [MAG_W-1:0]  sum_mg;
   logic signed [DATA_W-1:0] fin_pos;
   logic signed [DATA_W-1:0] fin_mom;
   logic                     fin_sat;
   logic        [ERR_W-1:0]  max_base;
   logic        [ERR_W-1:0]  max_in;
   logic        [ERR_W-1:0]  max_ff;

   // result register
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_pos_ff;
   logic signed [DATA_W-1:0] rsp_mom_ff;
   logic        [ERR_W-1:0]  rsp_err_ff;
   logic                     rsp_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= TIME_STEP_RESET;
      end else if (csr_write) begin
         time_step_ff <= csr_time_step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         clear_ff  <= req_clear_max;
         pos_ff    <= req_position;
         mom_ff    <= req_momentum;
         fnow_ff   <= req_force_now;
         fpred_ff  <= req_force_pred;
         imass_ff  <= req_inv_mass;
      end
   end

   assign status.is_predict = (action_ff == ACT_PREDICT);
   assign status.is_correct = (action_ff == ACT_CORRECT);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      opx     = '0;
      op_y_in = time_step_ff;
      case (cmd.op_tag)
         OP_A: begin
            opx     = MAG_W'(fpred_ff) - MAG_W'(fnow_ff);
            op_y_in = imass_ff;
         end
         OP_H: opx = MAG_W'(fnow_ff);
         OP_G: opx = MAG_W'(fpred_ff) + MAG_W'(fnow_ff);
         OP_B: opx = MAG_W'(a_ff);
         OP_V: opx = MAG_W'(mom_ff) + MAG_W'(hg_ff);
         OP_C: opx = MAG_W'(b_ff);
         OP_D: begin
            opx     = MAG_W'(v_ff);
            op_y_in = imass_ff;
         end
         default: begin
            opx = '0;
         end
      endcase
      op_mag_in = opx[MAG_W-1] ? $unsigned(-opx) : $unsigned(opx);
   end

   always_ff @(posedge clock) begin
      op_mag_ff  <= op_mag_in;
      op_y_ff    <= op_y_in;
      op_neg_ff  <= opx[MAG_W-1];
      prod_ff    <= PROD_W'(op_mag_ff) * PROD_W'(op_y_ff);
      mul_neg_ff <= op_neg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_tag_ff  <= OP_NONE;
         mul_tag_ff <= OP_NONE;
      end else begin
         op_tag_ff  <= cmd.op_tag;
         mul_tag_ff <= op_tag_ff;
      end
   end

   // round half away from zero, then saturate to the value range
   always_comb begin
      case (mul_tag_ff)
         OP_H, OP_G: begin
            rnd_sum = SUM_W'(prod_ff) + (SUM_W'(1) << (SHIFT_HALF - 1));
            rnd_q   = Q_W'(rnd_sum >> SHIFT_HALF);
         end
         OP_C: begin
            rnd_sum = SUM_W'(prod_ff) + (SUM_W'(1) << (SHIFT_QUARTER - 1));
            rnd_q   = Q_W'(rnd_sum >> SHIFT_QUARTER);
         end
         default: begin
            rnd_sum = SUM_W'(prod_ff) + (SUM_W'(1) << (SHIFT_MUL - 1));
            rnd_q   = Q_W'(rnd_sum >> SHIFT_MUL);
         end
      endcase
      if (mul_neg_ff) begin
         rnd_sat = rnd_q > MAX_Q1;
         rnd_val = rnd_sat ? VMIN_D : -$signed(rnd_q[DATA_W-1:0]);
      end else begin
         rnd_sat = rnd_q > MAX_Q;
         rnd_val = rnd_sat ? VMAX_D : $signed(rnd_q[DATA_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      case (mul_tag_ff)
         OP_A:       a_ff  <= rnd_val;
         OP_H, OP_G: hg_ff <= rnd_val;
         OP_B:       b_ff  <= rnd_val;
         OP_V:       v_ff  <= rnd_val;
         OP_C:       c_ff  <= rnd_val;
         OP_D:       d_ff  <= rnd_val;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_ff <= 1'b0;
      end else if (cmd.load) begin
         sat_ff <= 1'b0;
      end else if (mul_tag_ff != OP_NONE && rnd_sat) begin
         sat_ff <= 1'b1;
      end
   end

   always_comb begin
      err_cap_in = 1'b0;
      if (c_ff == VMIN_D) begin
         err_cap_in = 1'b1;
         err_in     = ERR_W'(VMAX_D);
      end else if (c_ff < 0) begin
         err_in = ERR_W'(-c_ff);
      end else begin
         err_in = ERR_W'(c_ff);
      end
   end

   always_ff @(posedge clock) begin
      err_ff     <= err_in;
      err_cap_ff <= err_cap_in;
   end

   always_comb begin
      sum_pd  = MAG_W'(pos_ff) + MAG_W'(d_ff);
      sum_pc  = MAG_W'(pos_ff) - MAG_W'(c_ff);
      sum_mg  = MAG_W'(mom_ff) + MAG_W'(hg_ff);
      fin_pos = pos_ff;
      fin_mom = mom_ff;
      fin_sat = 1'b0;
      case (action_ff)
         ACT_PREDICT: begin
            fin_pos = clip(sum_pd);
            fin_sat = clipped(sum_pd);
         end
         ACT_CORRECT: begin
            fin_pos = clip(sum_pc);
            fin_mom = clip(sum_mg);
            fin_sat = clipped(sum_pc) || clipped(sum_mg);
         end
         default: begin
            fin_sat = 1'b0;
         end
      endcase
      max_base = clear_ff ? '0 : max_ff;
      max_in   = (err_ff > max_base) ? err_ff : max_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         max_ff       <= '0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
         max_ff       <= max_in;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_pos_ff <= fin_pos;
         rsp_mom_ff <= fin_mom;
         rsp_err_ff <= err_ff;
         rsp_sat_ff <= sat_ff || err_cap_ff || fin_sat;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_new_position   = rsp_pos_ff;
   assign rsp_new_momentum   = rsp_mom_ff;
   assign rsp_position_error = rsp_err_ff;
   assign rsp_max_error      = max_ff;
   assign rsp_saturated      = rsp_sat_ff;

   `PPC_ASSERT(a_commit_drained, clock, reset, cmd.commit |-> (op_tag_ff == OP_NONE && mul_tag_ff == OP_NONE), "result committed with products in flight")
   `PPC_ASSERT(a_commit_free, clock, reset, cmd.commit |-> status.out_free, "result register overwritten while held")
   `PPC_ASSERT(a_max_covers_err, clock, reset, rsp_valid_ff |-> (max_ff >= rsp_err_ff), "running maximum below the error of its transaction")

endmodule

[rtl/particle_predictor_corrector_top.sv]
// particle predictor corrector: one coordinate step per transaction
// a result is registered when the final step commits it, once the result register is free
// a new transaction is taken only after the last one commits; one shared 33 x 32 multiplier runs
// up to six rounded products through an operand, product and rounding register chain
// the result register lets the next transaction start while a result is held
// reset clears control, sets the time step to 1677722 and the running maximum to zero

module particle_predictor_corrector_top #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic        [1:0]                   req_action,
   input  logic                                req_clear_max,
   input  logic signed [ppc_pkg::DATA_W-1:0]   req_position,
   input  logic signed [ppc_pkg::DATA_W-1:0]   req_momentum,
   input  logic signed [ppc_pkg::DATA_W-1:0]   req_force_now,
   input  logic signed [ppc_pkg::DATA_W-1:0]   req_force_pred,
   input  logic        [ppc_pkg::DATA_W-1:0]   req_inv_mass,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [ppc_pkg::DATA_W-1:0]   rsp_new_position,
   output logic signed [ppc_pkg::DATA_W-1:0]   rsp_new_momentum,
   output logic        [ppc_pkg::ERR_W-1:0]    rsp_position_error,
   output logic        [ppc_pkg::ERR_W-1:0]    rsp_max_error,
   output logic                                rsp_saturated,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic        [ppc_pkg::DATA_W-1:0]   csr_time_step
);
   import ppc_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          csr_write;

   assign csr_ready = !reset;
   assign csr_write = csr_valid && csr_ready;

   ppc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   ppc_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write          (csr_write),
      .csr_time_step      (csr_time_step),
      .req_action         (req_action),
      .req_clear_max      (req_clear_max),
      .req_position       (req_position),
      .req_momentum       (req_momentum),
      .req_force_now      (req_force_now),
      .req_force_pred     (req_force_pred),
      .req_inv_mass       (req_inv_mass),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_new_position   (rsp_new_position),
      .rsp_new_momentum   (rsp_new_momentum),
      .rsp_position_error (rsp_position_error),
      .rsp_max_error      (rsp_max_error),
      .rsp_saturated      (rsp_saturated)
   );

endmodule

[tb/sv/particle_predictor_corrector_top_test.sv]
// testbench for the particle predictor corrector: directed and random coordinate steps
`timescale 1ns / 100ps

module particle_predictor_corrector_top_test;
   import ppc_pkg::*;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam longint VALUE_MAX = 64'sd2147483647;
   localparam longint VALUE_MIN = -VALUE_MAX - 1;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 12;

   typedef struct packed {
      logic [1:0]                action;
      logic                      clear_max;
      logic signed [DATA_W-1:0]  position;
      logic signed [DATA_W-1:0]  momentum;
      logic signed [DATA_W-1:0]  force_now;
      logic signed [DATA_W-1:0]  force_pred;
      logic [DATA_W-1:0]         inv_mass;
   } coordinate_item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  new_position;
      logic signed [DATA_W-1:0]  new_momentum;
      logic [ERR_W-1:0]          position_error;
      logic [ERR_W-1:0]          max_error;
      logic                      saturated;
   } coordinate_result_type;

   typedef struct {
      coordinate_item_type   item;
      bit                    typed;
      coordinate_result_type result;
   } stimulus_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [1:0]                 req_action = ACT_PREDICT;
   logic                       req_clear_max = 1'b0;
   logic signed [DATA_W-1:0]   req_position = '0;
   logic signed [DATA_W-1:0]   req_momentum = '0;
   logic signed [DATA_W-1:0]   req_force_now = '0;
   logic signed [DATA_W-1:0]   req_force_pred = '0;
   logic [DATA_W-1:0]          req_inv_mass = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [DATA_W-1:0]   rsp_new_position;
   logic signed [DATA_W-1:0]   rsp_new_momentum;
   logic [ERR_W-1:0]           rsp_position_error;
   logic [ERR_W-1:0]           rsp_max_error;
   logic                       rsp_saturated;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [DATA_W-1:0]          csr_time_step = '0;

   logic [DATA_W-1:0]          step_model = TIME_STEP_RESET;
   logic [ERR_W-1:0]           max_error_model = '0;
   coordinate_result_type      expected_steps[$];
   stimulus_row_type           directed_rows[$];
   int unsigned                send_idle_pct = 0;
   int unsigned                stall_pct = 0;
   int unsigned                hold_requests = 0;
   int unsigned                holds_served = 0;
   int unsigned                hold_left = 0;
   int unsigned                results_seen = 0;
   int unsigned                mismatches = 0;

   particle_predictor_corrector_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_clear_max      (req_clear_max),
      .req_position       (req_position),
      .req_momentum       (req_momentum),
      .req_force_now      (req_force_now),
      .req_force_pred     (req_force_pred),
      .req_inv_mass       (req_inv_mass),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_new_position   (rsp_new_position),
      .rsp_new_momentum   (rsp_new_momentum),
      .rsp_position_error (rsp_position_error),
      .rsp_max_error      (rsp_max_error),
      .rsp_saturated      (rsp_saturated),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_time_step      (csr_time_step)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("particle_predictor_corrector_top test failed");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      mismatches++;
   endtask

   // (factor * scale) >> shift, rounded half away from zero, clipped to the value range
   function automatic longint round_product(input longint factor, input logic [31:0] scale,
                                            input int shift, inout bit clipped);
      logic [127:0] product;
      bit negative;
      negative = factor < 0;
      product = 128'(negative ? -factor : factor) * 128'(scale);
      product = (product + (128'd1 << (shift - 1))) >> shift;
      if (negative) begin
         if (product > 128'(VALUE_MAX + 1)) begin
            clipped = 1'b1;
            return VALUE_MIN;
         end
         return -longint'(product[63:0]);
      end
      if (product > 128'(VALUE_MAX)) begin
         clipped = 1'b1;
         return VALUE_MAX;
      end
      return longint'(product[63:0]);
   endfunction

   function automatic longint clip_value(input longint x, inout bit clipped);
      if (x > VALUE_MAX) begin
         clipped = 1'b1;
         return VALUE_MAX;
      end
      if (x < VALUE_MIN) begin
         clipped = 1'b1;
         return VALUE_MIN;
      end
      return x;
   endfunction

   function automatic coordinate_result_type integrate_coordinate(
      input coordinate_item_type it);
      coordinate_result_type res;
      longint r, p, f, ft, a, b, c, h, v, d, g, npos, nmom;
      logic [31:0] err;
      bit clipped;
      clipped = 1'b0;
      r = longint'($signed(it.position));
      p = longint'($signed(it.momentum));
      f = longint'($signed(it.force_now));
      ft = longint'($signed(it.force_pred));
      npos = r;
      nmom = p;
      a = round_product(ft - f, it.inv_mass, SHIFT_MUL, clipped);
      b = round_product(a, step_model, SHIFT_MUL, clipped);
      c = round_product(b, step_model, SHIFT_QUARTER, clipped);
      if (c < -VALUE_MAX) begin
         clipped = 1'b1;
         err = 32'(VALUE_MAX);
      end else begin
         err = 32'(c < 0 ? -c : c);
      end
      case (it.action)
         ACT_PREDICT: begin
            h = round_product(f, step_model, SHIFT_HALF, clipped);
            v = round_product(p + h, step_model, SHIFT_MUL, clipped);
            d = round_product(v, it.inv_mass, SHIFT_MUL, clipped);
            npos = clip_value(r + d, clipped);
         end
         ACT_CORRECT: begin
            g = round_product(ft + f, step_model, SHIFT_HALF, clipped);
            npos = clip_value(r - c, clipped);
            nmom = clip_value(p + g, clipped);
         end
         default: begin
         end
      endcase
      if (it.clear_max)
         max_error_model = '0;
      if (err > 32'(max_error_model))
         max_error_model = err[ERR_W-1:0];
      res.new_position = npos[31:0];
      res.new_momentum = nmom[31:0];
      res.position_error = err[ERR_W-1:0];
      res.max_error = max_error_model;
      res.saturated = clipped;
      return res;
   endfunction

   // typed rows have equal forces and expect position and momentum back untouched
   function automatic void add_row(input logic [1:0] action, input logic clear_max,
                                   input logic [31:0] r, input logic [31:0] p,
                                   input logic [31:0] f, input logic [31:0] ft,
                                   input logic [31:0] m, input bit typed);
      stimulus_row_type row;
      row.item = '{action, clear_max, r, p, f, ft, m};
      row.typed = typed;
      row.result = '{r, p, '0, '0, 1'b0};
      directed_rows.push_back(row);
   endfunction

   function automatic logic [31:0] random_value();
      logic [31:0] corners[5];
      corners = '{32'h0, 32'h1, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000};
      case ($urandom_range(7))
         0: return corners[$urandom_range(4)];
         1: return $urandom;
         default: return $urandom_range(32'h00FFFFFF) - 32'h00800000;
      endcase
   endfunction

   function automatic logic [31:0] random_mass();
      logic [31:0] corners[5];
      corners = '{32'h0, 32'h1, 32'hFFFFFFFF, 32'h80000000, 32'h01000000};
      case ($urandom_range(7))
         0: return corners[$urandom_range(4)];
         1: return $urandom;
         default: return $urandom_range(32'h04000000);
      endcase
   endfunction

   function automatic coordinate_item_type random_item();
      coordinate_item_type it;
      it.action = ($urandom_range(99) < 5) ? ACT_UNUSED : 2'($urandom_range(2));
      it.clear_max = ($urandom_range(9) == 0);
      it.position = random_value();
      it.momentum = random_value();
      it.force_now = random_value();
      it.force_pred = ($urandom_range(3) == 0) ? it.force_now : random_value();
      it.inv_mass = random_mass();
      return it;
   endfunction

   task automatic offer_coordinate(input coordinate_item_type it, input bit typed,
                                   input coordinate_result_type fixed);
      int gap;
      coordinate_result_type predicted;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= it.action;
      req_clear_max <= it.clear_max;
      req_position <= it.position;
      req_momentum <= it.momentum;
      req_force_now <= it.force_now;
      req_force_pred <= it.force_pred;
      req_inv_mass <= it.inv_mass;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = integrate_coordinate(it);
      expected_steps.push_back(typed ? fixed : predicted);
   endtask

   task automatic wait_drain();
      while (expected_steps.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_time_step(input logic [31:0] value);
      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_time_step <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      step_model = value;
   endtask

   task automatic run_random_phase(input int count, input int unsigned send_pct,
                                   input int unsigned recv_pct);
      send_idle_pct = send_pct;
      stall_pct = recv_pct;
      repeat (count)
         offer_coordinate(random_item(), 1'b0, '0);
      req_valid <= 1'b0;
   endtask

   always @(posedge clock) begin : result_monitor
      coordinate_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_steps.size() == 0) begin
            report_mismatch($sformatf("result transaction %0d with none outstanding",
                                      results_seen));
         end else begin
            want = expected_steps.pop_front();
            if (rsp_new_position !== want.new_position)
               report_mismatch($sformatf("transaction %0d new_position %h, expected %h",
                                         results_seen, rsp_new_position, want.new_position));
            if (rsp_new_momentum !== want.new_momentum)
               report_mismatch($sformatf("transaction %0d new_momentum %h, expected %h",
                                         results_seen, rsp_new_momentum, want.new_momentum));
            if (rsp_position_error !== want.position_error)
               report_mismatch($sformatf("transaction %0d position_error %h, expected %h",
                                         results_seen, rsp_position_error,
                                         want.position_error));
            if (rsp_max_error !== want.max_error)
               report_mismatch($sformatf("transaction %0d max_error %h, expected %h",
                                         results_seen, rsp_max_error, want.max_error));
            if (rsp_saturated !== want.saturated)
               report_mismatch($sformatf("transaction %0d saturated %b, expected %b",
                                         results_seen, rsp_saturated, want.saturated));
         end
         results_seen++;
      end
      // long hold-off so the block backs up into its input
      if (hold_requests != holds_served) begin
         holds_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   initial begin
      add_row(ACT_PREDICT, 1'b0, 32'h7FFFFFFF, 32'h0, 32'h0, 32'h0, 32'hFFFFFFFF, 1'b1);
      add_row(ACT_ERROR, 1'b0, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
              32'hFFFFFFFF, 1'b1);
      add_row(ACT_UNUSED, 1'b0, 32'h12345678, 32'h80000000, 32'h80000000, 32'h80000000,
              32'h0, 1'b1);
      add_row(ACT_CORRECT, 1'b0, 32'h80000000, 32'h80000000, 32'h0, 32'h0, 32'h01000000, 1'b1);
      add_row(ACT_CORRECT, 1'b0, 32'h0, 32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h0, 1'b0);
      add_row(ACT_PREDICT, 1'b0, 32'h00018000, 32'hFFFDC000, 32'h0000C000, 32'h00010000,
              32'h00800000, 1'b0);
      add_row(ACT_CORRECT, 1'b0, 32'h00018000, 32'hFFFDC000, 32'h0000C000, 32'h00010000,
              32'h00800000, 1'b0);
      add_row(ACT_ERROR, 1'b0, 32'h00018000, 32'hFFFDC000, 32'h0000C000, 32'h00010000,
              32'h00800000, 1'b0);
      add_row(ACT_ERROR, 1'b0, 32'h0, 32'h0, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b0);
      add_row(ACT_ERROR, 1'b0, 32'h0, 32'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 1'b0);
      add_row(ACT_ERROR, 1'b1, 32'h0, 32'h0, 32'h00010000, 32'h00020000, 32'h01000000, 1'b0);
      add_row(ACT_CORRECT, 1'b0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
              32'h80000000, 1'b0);
      add_row(ACT_CORRECT, 1'b0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
              32'h80000000, 1'b0);
      add_row(ACT_PREDICT, 1'b0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0,
              32'hFFFFFFFF, 1'b0);
      add_row(ACT_PREDICT, 1'b0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h0,
              32'hFFFFFFFF, 1'b0);
      add_row(ACT_PREDICT, 1'b1, 32'hFFFFFFFF, 32'h00000001, 32'hFFFFFFFF, 32'h00000001,
              32'h00000001, 1'b0);
      add_row(ACT_UNUSED, 1'b0, 32'h00050000, 32'hFFFF0000, 32'h00100000, 32'hFFF00000,
              32'h02000000, 1'b0);
      add_row(ACT_ERROR, 1'b1, 32'h0, 32'h0, 32'h00001000, 32'h00001800, 32'h01000000, 1'b0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         offer_coordinate(directed_rows[i].item, directed_rows[i].typed,
                          directed_rows[i].result);
      req_valid <= 1'b0;

      write_time_step(32'h0);
      run_random_phase(100, 0, 0);
      write_time_step(32'hFFFFFFFF);
      run_random_phase(120, 60, 0);
      write_time_step($urandom_range(32'h04000000, 32'h00100000));
      run_random_phase(150, 0, 60);
      write_time_step($urandom);
      run_random_phase(150, 11, 11);

      write_time_step(32'h01000000);
      hold_requests++;
      run_random_phase(60, 0, 0);

      write_time_step(32'h00000001);
      run_random_phase(80, 0, 0);
      write_time_step($urandom_range(32'h02000000, 32'h00010000));
      run_random_phase(100, 11, 11);

      wait_drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("particle_predictor_corrector_top test passed");
      else
         $display("particle_predictor_corrector_top test failed");
      $finish;
   end

endmodule
